// ----- design/sws_pkg.sv -----
package sws_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] RegWindow  = 2'd0;
  localparam logic [1:0] RegRto     = 2'd1;
  localparam logic [1:0] RegStart   = 2'd2;
  localparam logic [1:0] RegDupThr  = 2'd3;

  localparam logic KindSent  = 1'b0;
  localparam logic KindAcked = 1'b1;
  localparam logic FuncAck   = 1'b0;
  localparam logic FuncTick  = 1'b1;

  localparam logic [3:0] DupMax = 4'd15;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScRd  = 6'b000010,
    StScEv  = 6'b000100,
    StFlChk = 6'b001000,
    StFlWr  = 6'b010000,
    StFlush = 6'b100000
  } state_e;

  typedef struct packed {
    logic [31:0] seq;
    logic [47:0] tx_time;
    logic [3:0]  dup;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] seq;
    logic        retx;
    logic [47:0] rtt;
  } result_t;

endpackage

// ----- design/sws_ram.sv -----
module sws_ram import sws_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sliding_window_sender.sv -----
// sliding window sender: ack retirement, duplicate ack fast retransmit, timeout
// retransmit and window fill over a queue memory and a retransmit stack memory
// per item: the scan reads and evaluates each outstanding entry, then the fill checks
// and writes each packet sent, then the held-back last result is flushed;
// one item in flight at a time (single queue read port); output stalls hold it longer
// reset: counters cleared, highest ack and next sequence loaded with 1
module sliding_window_sender import sws_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_func_i,
  input  logic [31:0] in_ack_num_i,
  input  logic [47:0] in_now_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [31:0] out_seq_o,
  output logic        out_retransmitted_o,
  output logic [47:0] out_rtt_o,
  output logic        out_last_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  // configuration registers
  logic [4:0]  window_q;
  logic [47:0] rto_q;
  logic [3:0]  dup_thr_q;

  // control state
  state_e      state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;      // outstanding entries
  logic [CW-1:0] sc_q, sc_d;        // retransmit stack depth
  logic [CW-1:0] idx_q, idx_d;      // scan read position
  logic [CW-1:0] wp_q, wp_d;        // scan compaction write position
  logic          first_q, first_d;  // next kept entry is the oldest one
  logic          pop_q, pop_d;      // fill takes its sequence from the stack
  logic [31:0] ha_q, ha_d;
  logic [31:0] nseq_q, nseq_d;

  // latched item
  logic        func_q;
  logic [31:0] ack_q;
  logic [47:0] now_q;

  // one result held back until we know whether it is the last of the item
  logic        pend_v_q, pend_v_d;
  result_t     pend_q, pend_d;

  // output register
  logic        out_v_q;
  result_t     out_q;
  logic        out_last_q;
  logic        out_load;
  logic        out_last_d;

  // memories
  logic          q_we, q_re, s_we, s_re;
  logic [AW-1:0] q_waddr, q_raddr, s_waddr, s_raddr;
  entry_t        q_wdata, q_rdata;
  logic [31:0]   s_wdata, s_rdata;

  // scan helpers
  logic          out_free;
  logic [5:0]    win6;
  logic [3:0]    dup_new;
  logic          retire, timed_out, dup_drop;
  logic [48:0]   expire;

  function automatic logic [47:0] in_now_sub(logic [47:0] a, logic [47:0] b);
    return a - b;
  endfunction

  assign out_free = !out_v_q || !out_stall_i;
  assign win6 = ({1'b0, window_q} > 6'(WINDOW)) ? 6'(WINDOW) : {1'b0, window_q};
  assign expire = {1'b0, q_rdata.tx_time} + {1'b0, rto_q};

  assign retire = q_rdata.seq < ha_q;
  assign timed_out = expire <= {1'b0, now_q};
  assign dup_new = (first_q && func_q == FuncAck && q_rdata.seq == ha_q && ack_q == ha_q
                    && q_rdata.dup < DupMax) ? q_rdata.dup + 4'd1 : q_rdata.dup;
  assign dup_drop = first_q && (dup_new >= dup_thr_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sc_d     = sc_q;
    idx_d    = idx_q;
    wp_d     = wp_q;
    first_d  = first_q;
    pop_d    = pop_q;
    ha_d     = ha_q;
    nseq_d   = nseq_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_load = 1'b0;
    out_last_d = 1'b0;
    q_we = 1'b0;
    q_re = 1'b0;
    q_waddr = '0;
    q_raddr = idx_q[AW-1:0];
    q_wdata = q_rdata;
    s_we = 1'b0;
    s_re = 1'b0;
    s_waddr = sc_q[AW-1:0];
    s_raddr = '0;
    s_wdata = q_rdata.seq;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_func_i == FuncAck && in_ack_num_i > ha_q) begin
            ha_d = in_ack_num_i;
          end
          idx_d   = '0;
          wp_d    = '0;
          first_d = 1'b1;
          state_d = StScRd;
        end
      end
      StScRd: begin
        if (idx_q < cnt_q) begin
          q_re    = 1'b1;
          state_d = StScEv;
        end else begin
          cnt_d   = wp_q;
          state_d = StFlChk;
        end
      end
      StScEv: begin
        if (retire) begin
          // acknowledged entry: report it, it leaves the queue
          if (!pend_v_q || out_free) begin
            out_load = pend_v_q;
            pend_v_d = 1'b1;
            pend_d   = '{kind: KindAcked, seq: q_rdata.seq, retx: 1'b0,
                         rtt: in_now_sub(now_q, q_rdata.tx_time)};
            idx_d    = idx_q + 1'b1;
            state_d  = StScRd;
          end
        end else begin
          first_d = 1'b0;
          if (dup_drop || timed_out) begin
            if (sc_q < CW'(WINDOW)) begin
              s_we = 1'b1;
              sc_d = sc_q + 1'b1;
            end
          end else begin
            // compaction write stays at or behind the read position
            q_we    = 1'b1;
            q_waddr = wp_q[AW-1:0];
            q_wdata = '{seq: q_rdata.seq, tx_time: q_rdata.tx_time, dup: dup_new};
            wp_d    = wp_q + 1'b1;
          end
          idx_d   = idx_q + 1'b1;
          state_d = StScRd;
        end
      end
      StFlChk: begin
        if (6'(cnt_q) < win6) begin
          if (sc_q != '0) begin
            s_re    = 1'b1;
            s_raddr = AW'(sc_q - 1'b1);
            sc_d    = sc_q - 1'b1;
            pop_d   = 1'b1;
          end else begin
            pop_d   = 1'b0;
          end
          state_d = StFlWr;
        end else begin
          state_d = StFlush;
        end
      end
      StFlWr: begin
        if (!pend_v_q || out_free) begin
          out_load = pend_v_q;
          pend_v_d = 1'b1;
          pend_d   = '{kind: KindSent, seq: pop_q ? s_rdata : nseq_q, retx: pop_q,
                       rtt: '0};
          if (!pop_q) begin
            nseq_d = nseq_q + 32'd1;
          end
          q_we    = 1'b1;
          q_waddr = cnt_q[AW-1:0];
          q_wdata = '{seq: pop_q ? s_rdata : nseq_q, tx_time: now_q, dup: 4'd0};
          cnt_d   = cnt_q + 1'b1;
          state_d = StFlChk;
        end
      end
      StFlush: begin
        if (!pend_v_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // start_seq reload, taken only while idle
    if (cfg_valid_i && cfg_ready_o && cfg_index_i == RegStart) begin
      ha_d   = cfg_data_i[31:0];
      nseq_d = cfg_data_i[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      sc_q      <= '0;
      idx_q     <= '0;
      wp_q      <= '0;
      first_q   <= 1'b0;
      pop_q     <= 1'b0;
      ha_q      <= 32'd1;
      nseq_q    <= 32'd1;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      window_q  <= 5'd1;
      rto_q     <= 48'd3000000000;
      dup_thr_q <= 4'd3;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sc_q     <= sc_d;
      idx_q    <= idx_d;
      wp_q     <= wp_d;
      first_q  <= first_d;
      pop_q    <= pop_d;
      ha_q     <= ha_d;
      nseq_q   <= nseq_d;
      pend_v_q <= pend_v_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegWindow: window_q  <= cfg_data_i[4:0];
          RegRto:    rto_q     <= cfg_data_i;
          RegDupThr: dup_thr_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (state_q == StIdle && in_valid_i) begin
      func_q <= in_func_i;
      ack_q  <= in_ack_num_i;
      now_q  <= in_now_i;
    end
    if (out_load) begin
      out_q      <= pend_q;
      out_last_q <= out_last_d;
    end
  end

  sws_ram #(.Width($bits(entry_t)), .Depth(WINDOW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  sws_ram #(.Width(32), .Depth(WINDOW)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // configuration only between items; an arriving item takes precedence
  assign in_stall_o          = (state_q != StIdle);
  assign cfg_ready_o         = (state_q == StIdle) && !in_valid_i;
  assign out_valid_o         = out_v_q;
  assign out_kind_o          = out_q.kind;
  assign out_seq_o           = out_q.seq;
  assign out_retransmitted_o = out_q.retx;
  assign out_rtt_o           = out_q.rtt;
  assign out_last_o          = out_last_q;

endmodule

// ----- sim/sliding_window_sender_tb.sv -----
module sliding_window_sender_tb;
  import sws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic        kind;
    logic [31:0] seq;
    logic        retx;
    logic [47:0] rtt;
    logic        last;
  } pkt_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        in_func_i = 1'b0;
  logic [31:0] in_ack_num_i = '0;
  logic [47:0] in_now_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_kind_o;
  logic [31:0] out_seq_o;
  logic        out_retransmitted_o;
  logic [47:0] out_rtt_o;
  logic        out_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  sliding_window_sender dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shadow copy of the window tracker
  logic [4:0]  m_window;
  logic [47:0] m_rto;
  logic [3:0]  m_thr;
  logic [31:0] q_seq [Depth];
  logic [47:0] q_time [Depth];
  logic [3:0]  q_dup [Depth];
  int          q_cnt;
  logic [31:0] hi_ack, nxt_seq;
  logic [31:0] stk [Depth];
  int          stk_cnt;

  pkt_event_t  pending_events[$];
  int          fail_cnt = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  logic [47:0] clock_now = '0;

  // hand-typed expectation for the first directed tick
  logic        use_fixed;
  pkt_event_t  fixed_q[$];

  task automatic drop_at(input int pos);
    for (int k = pos; k + 1 < q_cnt; k++) begin
      q_seq[k] = q_seq[k+1];
      q_time[k] = q_time[k+1];
      q_dup[k] = q_dup[k+1];
    end
    q_cnt--;
  endtask

  task automatic push_stack(input logic [31:0] s);
    if (stk_cnt < Depth) begin
      stk[stk_cnt] = s;
      stk_cnt++;
    end
  endtask

  task automatic add_event(input logic k, input logic [31:0] s, input logic r,
                           input logic [47:0] t);
    pkt_event_t e;
    e.kind = k; e.seq = s; e.retx = r; e.rtt = t; e.last = 1'b0;
    pending_events.push_back(e);
  endtask

  task automatic track_window(input logic f, input logic [31:0] ack, input logic [47:0] now);
    int i, win, first;
    logic [31:0] s;
    logic r;
    first = pending_events.size();
    if (f == FuncAck && ack > hi_ack) hi_ack = ack;
    i = 0;
    while (i < q_cnt) begin
      if (q_seq[i] < hi_ack) begin
        add_event(KindAcked, q_seq[i], 1'b0, now - q_time[i]);
        drop_at(i);
      end else i++;
    end
    if (q_cnt > 0) begin
      if (f == FuncAck && q_seq[0] == hi_ack && ack == hi_ack && q_dup[0] < DupMax)
        q_dup[0]++;
      if (q_dup[0] >= m_thr) begin
        push_stack(q_seq[0]);
        drop_at(0);
      end
    end
    i = 0;
    while (i < q_cnt) begin
      if (49'(q_time[i]) + 49'(m_rto) <= 49'(now)) begin
        push_stack(q_seq[i]);
        drop_at(i);
      end else i++;
    end
    win = (m_window > Depth) ? Depth : int'(m_window);
    while (q_cnt < win) begin
      if (stk_cnt > 0) begin
        stk_cnt--;
        s = stk[stk_cnt];
        r = 1'b1;
      end else begin
        s = nxt_seq;
        nxt_seq = nxt_seq + 32'd1;
        r = 1'b0;
      end
      q_seq[q_cnt] = s;
      q_time[q_cnt] = now;
      q_dup[q_cnt] = '0;
      q_cnt++;
      add_event(KindSent, s, r, '0);
    end
    if (pending_events.size() > first) pending_events[$].last = 1'b1;
  endtask

  task automatic shadow_config(input logic [1:0] idx, input logic [47:0] v);
    case (idx)
      RegWindow: m_window = v[4:0];
      RegRto:    m_rto = v;
      RegStart: begin
        hi_ack = v[31:0];
        nxt_seq = v[31:0];
      end
      RegDupThr: m_thr = v[3:0];
      default: ;
    endcase
  endtask

  // random gap, mostly short with an occasional long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [47:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    shadow_config(idx, v);
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic f, input logic [31:0] ack, input logic [47:0] now);
    in_valid_i <= 1'b1;
    in_func_i <= f;
    in_ack_num_i <= ack;
    in_now_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_window(f, ack, now);
    if (use_fixed) begin
      if (fixed_q.size() != pending_events.size()) begin
        $display("%0t directed count expected %0d actual %0d", $time,
                 fixed_q.size(), pending_events.size());
        fail_cnt++;
      end
      use_fixed = 1'b0;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    repeat (gap_len()) @(posedge clk_i);
  endtask

  // wait for drain plus the block's tail latency
  task automatic settle();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // result side: random stall and compare
  always @(posedge clk_i) begin
    pkt_event_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          $display("%0t unexpected result seq %h", $time, out_seq_o);
          fail_cnt++;
        end else begin
          e = pending_events.pop_front();
          if (fixed_q.size() != 0) begin
            e = fixed_q.pop_front();
          end
          if (out_kind_o !== e.kind || out_seq_o !== e.seq ||
              out_retransmitted_o !== e.retx || out_rtt_o !== e.rtt ||
              out_last_o !== e.last) begin
            $display("%0t mismatch expected k%0d s%h r%0d t%h l%0d actual k%0d s%h r%0d t%h l%0d",
                     $time, e.kind, e.seq, e.retx, e.rtt, e.last, out_kind_o,
                     out_seq_o, out_retransmitted_o, out_rtt_o, out_last_o);
            fail_cnt++;
          end
        end
      end
      if (stall_left == 0 && $urandom_range(0, 99) < 30) stall_left = gap_len();
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    logic        f;
    logic [31:0] ack;
    logic [47:0] now;
    logic        fixed;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic dir_row_t mk(input logic f, input logic [31:0] a,
                                  input logic [47:0] n, input logic x);
    dir_row_t d;
    d.f = f; d.ack = a; d.now = n; d.fixed = x;
    return d;
  endfunction

  initial begin
    logic [31:0] base;
    logic [47:0] step;
    int p;
    pkt_event_t fe;
    m_window = 5'd1; m_rto = 48'd3000000000; m_thr = 4'd3;
    hi_ack = 32'd1; nxt_seq = 32'd1; q_cnt = 0; stk_cnt = 0;
    use_fixed = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first tick after reset sends sequence 1
    fe.kind = KindSent; fe.seq = 32'd1; fe.retx = 1'b0; fe.rtt = '0; fe.last = 1'b1;
    fixed_q.push_back(fe);
    use_fixed = 1'b1;
    send_item(FuncTick, 32'hffff_ffff, 48'd100);
    settle();

    // directed table: dup acks, threshold, timeout, extremes
    dir_tab.push_back(mk(FuncAck, 32'd1, 48'd200, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'd1, 48'd300, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'd1, 48'd400, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'd2, 48'd500, 1'b0));
    dir_tab.push_back(mk(FuncTick, 32'd0, 48'd3000000600, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'd0, 48'd10, 1'b0));
    foreach (dir_tab[k])
      send_item(dir_tab[k].f, dir_tab[k].ack, dir_tab[k].now);
    settle();

    cfg_write(RegWindow, 48'd16);
    cfg_write(RegRto, 48'hffff_ffff_ffff);
    cfg_write(RegDupThr, 48'd15);
    cfg_write(RegStart, 48'hffff_fffe);
    dir_tab.delete();
    dir_tab.push_back(mk(FuncTick, 32'd0, 48'd1000, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'hffff_ffff, 48'hffff_ffff_fff0, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'hffff_ffff, 48'hffff_ffff_ffff, 1'b0));
    dir_tab.push_back(mk(FuncAck, 32'hffff_ffff, 48'd5, 1'b0));
    foreach (dir_tab[k])
      send_item(dir_tab[k].f, dir_tab[k].ack, dir_tab[k].now);
    settle();
    cfg_write(RegDupThr, 48'd0);
    send_item(FuncTick, 32'd0, 48'd6);
    send_item(FuncAck, 32'h5555_aaaa, 48'd7);
    settle();
    cfg_write(RegWindow, 48'd0);
    send_item(FuncAck, 32'hffff_ffff, 48'd8);
    settle();
    cfg_write(RegWindow, 48'd31);
    send_item(FuncTick, 32'd0, 48'd9);
    settle();

    // random phases: mostly well-formed ack progressions, some random acks and times
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(RegWindow, 48'($urandom_range(1, 16)));
      cfg_write(RegRto, (ph == 4) ? 48'd1 : 48'($urandom_range(50, 3000)));
      cfg_write(RegDupThr, 48'($urandom_range(1, 15)));
      base = $urandom;
      if (ph == 0) base = 32'hffff_fff8;
      cfg_write(RegStart, 48'(base));
      clock_now = clock_now + 48'd100;
      for (int n = 0; n < 19; n++) begin
        step = 48'($urandom_range(0, 400));
        clock_now = clock_now + step;
        p = $urandom_range(0, 99);
        if (p < 55)
          send_item(FuncAck, hi_ack + 32'($urandom_range(0, 3)), clock_now);
        else if (p < 75)
          send_item(FuncAck, hi_ack, clock_now);
        else if (p < 90)
          send_item(FuncTick, $urandom, clock_now);
        else
          send_item(FuncAck, $urandom, 48'({$urandom, $urandom}));
      end
      settle();
    end

    if (fail_cnt == 0 && pending_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sws_pkg.sv
design/sws_ram.sv
design/sliding_window_sender.sv
sim/sliding_window_sender_tb.sv
